>>> design/sharpen_3x3_filter_top_macros.svh
// assertion macros shared by the sharpen filter modules
// expects clk and arst_n in the scope of every use
`ifndef SHARPEN_3X3_FILTER_TOP_MACROS_SVH
`define SHARPEN_3X3_FILTER_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define SF3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define SF3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sf3_pkg.sv
// shared types, constants and helpers of the 3x3 sharpen filter
// no dependencies
`timescale 1ns / 1ps

package sf3_pkg;

	// frame geometry
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MIN_SIZE      = 3;
	localparam int WIDTH_RST     = 640;
	localparam int HEIGHT_RST    = 480;
	localparam int FW_BITS       = 11;
	localparam int ROW_W         = 12;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// pixel layout: channel 2 red, 1 green, 0 blue
	localparam int NCH  = 3;
	localparam int CH_R = 2;
	localparam int CH_G = 1;
	localparam int CH_B = 0;
	localparam int NRES = 3;

	typedef logic [NCH-1:0][7:0] pix_t;
	// one window column: 0 row y-2, 1 row y-1, 2 row y
	typedef pix_t [2:0] col3_t;

	localparam logic signed [12:0] PIX_MAX = 13'sd255;

	// clamp a signed kernel sum to the 8-bit pixel range
	function automatic logic [7:0] clamp_u8(input logic signed [12:0] v);
		logic [7:0] r;
		if (v < 13'sd0) begin
			r = 8'd0;
		end else if (v > PIX_MAX) begin
			r = 8'hff;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

>>> design/sharpen_3x3_filter_top.sv
// top level of the 3x3 laplacian sharpen filter: config, counters, line stores, window
// depends on sf3_pkg, sf3_line_ram, sf3_kernel, sf3_emit and the assertion macro header
`timescale 1ns / 1ps
`include "sharpen_3x3_filter_top_macros.svh"

// Sharpens a raster-order RGB stream with the 3x3 kernel 9*center minus the
// eight neighbors, clamped to 0..255; first and last rows and columns are
// copied. The block counts column and row itself from frame_width and
// frame_height; either register write restarts the frame at column 0, row 0.
// Rows 0 and H-1 come out as they arrive, every other row one row late, so a
// pixel causes zero to three result beats, the final one flagged last_of_run.
// A pixel is accepted every cycle while each pixel causes at most one beat and
// results are taken; a pixel causing more beats stalls the input while they go
// out, since the single result register sends one beat a cycle unless stalled
// (last column: two, last row: up to three). A pixel's first result passes
// through the stage 1 register, the group buffer and the output register before
// it shows on the result port. The line stores need no clearing after reset.
module sharpen_3x3_filter_top #(
	parameter int MAX_WIDTH = sf3_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sf3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sf3_pkg::CFG_DATA_W-1:0]   cfg_data,
	// pixel channel
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  logic [7:0]                       red_in,
	input  logic [7:0]                       green_in,
	input  logic [7:0]                       blue_in,
	// result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [7:0]                       red_out,
	output logic [7:0]                       green_out,
	output logic [7:0]                       blue_out,
	output logic [$clog2(MAX_WIDTH)-1:0]     pixel_column,
	output logic [sf3_pkg::ROW_W-1:0]        pixel_row,
	output logic                             last_of_run
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WC_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W = sf3_pkg::ROW_W;
	localparam int W_RST = (sf3_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : sf3_pkg::WIDTH_RST;

	logic [WC_W-1:0]  w_q;
	logic [ROW_W-1:0] h_q;
	logic [COL_W-1:0] x_q;
	logic [ROW_W-1:0] y_q;

	logic [sf3_pkg::FW_BITS-1:0] fw_raw;
	logic [WC_W-1:0]             w_next;
	logic [ROW_W-1:0]            h_next;
	logic                        cfg_wr;
	logic                        accept;
	logic                        row_end;

	logic             s1_valid_q;
	sf3_pkg::pix_t    cur_s1;
	logic [COL_W-1:0] x_s1;
	logic [ROW_W-1:0] y_s1;

	sf3_pkg::pix_t    pix_in;
	sf3_pkg::pix_t    older_rd;
	sf3_pkg::pix_t    newer_rd;
	sf3_pkg::col3_t   col3;
	sf3_pkg::col3_t   win0_q;
	sf3_pkg::col3_t   win1_q;
	sf3_pkg::pix_t    sharp;

	logic                     y_first;
	logic                     y_ge2;
	logic                     x_first;
	logic                     x_ge2;
	logic                     x_last;
	logic                     y_last;
	logic [sf3_pkg::NRES-1:0] grp_mask;
	sf3_pkg::pix_t            grp_pix [sf3_pkg::NRES];
	logic [COL_W-1:0]         grp_col [sf3_pkg::NRES];
	logic [ROW_W-1:0]         grp_row [sf3_pkg::NRES];
	logic                     grp_valid;
	logic                     grp_ready;
	logic                     s1_go;
	sf3_pkg::pix_t            res_pix;

	// configuration registers, sizes clamped when written
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready &&
		(cfg_index == sf3_pkg::REG_FRAME_WIDTH || cfg_index == sf3_pkg::REG_FRAME_HEIGHT);
	assign fw_raw    = cfg_data[sf3_pkg::FW_BITS-1:0];

	always_comb begin
		if (fw_raw < sf3_pkg::FW_BITS'(sf3_pkg::MIN_SIZE)) begin
			w_next = WC_W'(sf3_pkg::MIN_SIZE);
		end else if (int'(fw_raw) > MAX_WIDTH) begin
			w_next = WC_W'(MAX_WIDTH);
		end else begin
			w_next = WC_W'(fw_raw);
		end
		if (cfg_data < ROW_W'(sf3_pkg::MIN_SIZE)) begin
			h_next = ROW_W'(sf3_pkg::MIN_SIZE);
		end else begin
			h_next = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WC_W'(W_RST);
			h_q <= ROW_W'(sf3_pkg::HEIGHT_RST);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == sf3_pkg::REG_FRAME_WIDTH) begin
				w_q <= w_next;
			end
			if (cfg_index == sf3_pkg::REG_FRAME_HEIGHT) begin
				h_q <= h_next;
			end
		end
	end

	// pixel handshake
	assign pixel_stall = s1_valid_q && !s1_go;
	assign accept      = pixel_valid && !pixel_stall;

	assign pix_in[sf3_pkg::CH_R] = red_in;
	assign pix_in[sf3_pkg::CH_G] = green_in;
	assign pix_in[sf3_pkg::CH_B] = blue_in;

	// raster position of the next beat
	assign row_end = (WC_W'(x_q) + WC_W'(1)) >= w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cfg_wr) begin
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				x_q <= '0;
				y_q <= ((ROW_W + 1)'(y_q) + 1'b1 >= (ROW_W + 1)'(h_q)) ? '0 : y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	// line stores: newer written on accept, older takes the displaced entry on leaving s1
	sf3_line_ram #(.DEPTH(MAX_WIDTH)) u_ram_newer (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (x_q),
		.wr_data (pix_in),
		.rd_en   (accept),
		.rd_addr (x_q),
		.rd_data (newer_rd)
	);

	sf3_line_ram #(.DEPTH(MAX_WIDTH)) u_ram_older (
		.clk     (clk),
		.wr_en   (s1_go),
		.wr_addr (x_s1),
		.wr_data (newer_rd),
		.rd_en   (accept),
		.rd_addr (x_q),
		.rd_data (older_rd)
	);

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1 <= pix_in;
			x_s1   <= x_q;
			y_s1   <= y_q;
		end
	end

	// current column of the window
	assign col3[0] = older_rd;
	assign col3[1] = newer_rd;
	assign col3[2] = cur_s1;

	// two-column window shifts as each beat leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (s1_go) begin
			win0_q <= win1_q;
			win1_q <= col3;
		end
	end

	sf3_kernel u_kernel (
		.left  (win0_q),
		.mid   (win1_q),
		.right (col3),
		.sharp (sharp)
	);

	// position classes of the beat in stage 1
	assign y_first = (y_s1 == '0);
	assign y_ge2   = (y_s1 >= ROW_W'(2));
	assign x_first = (x_s1 == '0);
	assign x_ge2   = (x_s1 >= COL_W'(2));
	assign x_last  = (WC_W'(x_s1) == w_q - 1'b1);
	assign y_last  = (y_s1 == h_q - 1'b1);

	// slot 0: first-row copy, left-edge copy or sharpened pixel
	// slot 1: right-edge copy, slot 2: last-row copy
	always_comb begin
		grp_mask[0] = y_first || (y_ge2 && (x_first || x_ge2));
		grp_mask[1] = y_ge2 && x_last;
		grp_mask[2] = y_ge2 && y_last;

		if (y_first) begin
			grp_pix[0] = cur_s1;
			grp_col[0] = x_s1;
			grp_row[0] = '0;
		end else if (x_first) begin
			grp_pix[0] = newer_rd;
			grp_col[0] = '0;
			grp_row[0] = y_s1 - 1'b1;
		end else begin
			grp_pix[0] = sharp;
			grp_col[0] = x_s1 - 1'b1;
			grp_row[0] = y_s1 - 1'b1;
		end

		grp_pix[1] = newer_rd;
		grp_col[1] = COL_W'(w_q - 1'b1);
		grp_row[1] = y_s1 - 1'b1;

		grp_pix[2] = cur_s1;
		grp_col[2] = x_s1;
		grp_row[2] = y_s1;
	end

	assign grp_valid = s1_valid_q && (grp_mask != '0);
	assign s1_go     = s1_valid_q && ((grp_mask == '0) || grp_ready);

	sf3_emit #(.COL_W(COL_W)) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp_mask  (grp_mask),
		.grp_pix   (grp_pix),
		.grp_col   (grp_col),
		.grp_row   (grp_row),
		.res_valid (result_valid),
		.res_stall (result_stall),
		.res_pix   (res_pix),
		.res_col   (pixel_column),
		.res_row   (pixel_row),
		.res_last  (last_of_run)
	);

	assign red_out   = res_pix[sf3_pkg::CH_R];
	assign green_out = res_pix[sf3_pkg::CH_G];
	assign blue_out  = res_pix[sf3_pkg::CH_B];

	// checks
	`SF3_ASSERT_NOW(a_col_in_frame, 1'b1, WC_W'(x_q) < w_q, "column counter beyond frame width")
	`SF3_ASSERT_NEXT(a_frame_wrap, accept && !cfg_wr && row_end && (y_q == h_q - 1'b1),
		(x_q == '0) && (y_q == '0), "frame did not wrap after its last pixel")
	`SF3_ASSERT_NEXT(a_s1_order, s1_go && !accept, !s1_valid_q,
		"stage 1 kept a beat it had passed on")

endmodule

>>> design/sf3_line_ram.sv
// one line store: single write port, single registered read port
// depends on sf3_pkg for the pixel type
`timescale 1ns / 1ps

module sf3_line_ram #(
	parameter int DEPTH = sf3_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  sf3_pkg::pix_t            wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output sf3_pkg::pix_t            rd_data
);

	sf3_pkg::pix_t mem [DEPTH];
	sf3_pkg::pix_t rd_data_q;

	// read-first: a read of the address being written returns the old entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/sf3_kernel.sv
// 3x3 laplacian sharpen of one window, per channel, clamped to 0..255
// depends on sf3_pkg for pixel types and the clamp helper
`timescale 1ns / 1ps

module sf3_kernel (
	input  sf3_pkg::col3_t left,
	input  sf3_pkg::col3_t mid,
	input  sf3_pkg::col3_t right,
	output sf3_pkg::pix_t  sharp
);

	// channels are independent
	for (genvar ch = 0; ch < sf3_pkg::NCH; ch++) begin : g_ch
		logic        [10:0] nsum;
		logic        [11:0] c9;
		logic signed [12:0] diff;

		// sum of the eight neighbors, at most 8 * 255
		assign nsum = 11'(left[0][ch]) + 11'(left[1][ch]) + 11'(left[2][ch])
			+ 11'(mid[0][ch]) + 11'(mid[2][ch])
			+ 11'(right[0][ch]) + 11'(right[1][ch]) + 11'(right[2][ch]);

		// nine times the center as shift and add
		assign c9   = {1'b0, mid[1][ch], 3'b000} + 12'(mid[1][ch]);
		assign diff = $signed({1'b0, c9}) - $signed({2'b00, nsum});

		assign sharp[ch] = sf3_pkg::clamp_u8(diff);
	end

endmodule

>>> design/sf3_emit.sv
// result group buffer and output register: sends up to three results per pixel
// depends on sf3_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sharpen_3x3_filter_top_macros.svh"

module sf3_emit #(
	parameter int COL_W = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// group from the window stage
	input  logic                         grp_valid,
	output logic                         grp_ready,
	input  logic [sf3_pkg::NRES-1:0]     grp_mask,
	input  sf3_pkg::pix_t                grp_pix [sf3_pkg::NRES],
	input  logic [COL_W-1:0]             grp_col [sf3_pkg::NRES],
	input  logic [sf3_pkg::ROW_W-1:0]    grp_row [sf3_pkg::NRES],
	// result channel
	output logic                         res_valid,
	input  logic                         res_stall,
	output sf3_pkg::pix_t                res_pix,
	output logic [COL_W-1:0]             res_col,
	output logic [sf3_pkg::ROW_W-1:0]    res_row,
	output logic                         res_last
);

	logic [sf3_pkg::NRES-1:0]  mask_s2;
	sf3_pkg::pix_t             pix_s2 [sf3_pkg::NRES];
	logic [COL_W-1:0]          col_s2 [sf3_pkg::NRES];
	logic [sf3_pkg::ROW_W-1:0] row_s2 [sf3_pkg::NRES];

	logic                      out_valid_q;
	sf3_pkg::pix_t             out_pix_q;
	logic [COL_W-1:0]          out_col_q;
	logic [sf3_pkg::ROW_W-1:0] out_row_q;
	logic                      out_last_q;

	logic [1:0]                sel;
	logic [sf3_pkg::NRES-1:0]  rest;
	logic                      out_free;
	logic                      load;

	// oldest pending result of the group goes first
	always_comb begin
		priority if (mask_s2[0]) begin
			sel = 2'd0;
		end else if (mask_s2[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end

	assign rest      = mask_s2 & ~(sf3_pkg::NRES'(1) << sel);
	assign out_free  = !out_valid_q || !res_stall;
	assign load      = (mask_s2 != '0) && out_free;
	assign grp_ready = (mask_s2 == '0) || (load && (rest == '0));

	// group buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (grp_valid && grp_ready) begin
			mask_s2 <= grp_mask;
		end else if (load) begin
			mask_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid && grp_ready) begin
			pix_s2 <= grp_pix;
			col_s2 <= grp_col;
			row_s2 <= grp_row;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pix_q  <= pix_s2[sel];
			out_col_q  <= col_s2[sel];
			out_row_q  <= row_s2[sel];
			out_last_q <= (rest == '0);
		end
	end

	assign res_valid = out_valid_q;
	assign res_pix   = out_pix_q;
	assign res_col   = out_col_q;
	assign res_row   = out_row_q;
	assign res_last  = out_last_q;

	// checks
	`SF3_ASSERT_NOW(a_grp_nonempty, grp_valid, grp_mask != '0, "empty result group offered")
	`SF3_ASSERT_NOW(a_run_pending, out_valid_q && !out_last_q, mask_s2 != '0,
		"beat not marked last but no result pending")
	`SF3_ASSERT_NEXT(a_group_order, load && (rest != '0), !load || (sel > $past(sel)),
		"results of one group left out of order")

endmodule
